### hdl/shcf_pkg.sv
// Package for the sensor hit cluster finder.
// Holds field widths, parameter defaults and the register reset value.
// No dependencies.
package shcf_pkg;
	localparam int MAX_SENSORS_DEF     = 4096;
	localparam int NEIGHBOUR_COUNT_DEF = 8;
	localparam int CLUSTER_SIZE_DEF    = 9;

	localparam int IDX_W  = 12;
	localparam int CHG_W  = 16;
	localparam int TIME_W = 16;
	localparam int POS_W  = 17;
	localparam int THR_W  = 4;

	localparam logic [THR_W-1:0] THR_RESET = 4'd4;
	localparam logic [TIME_W-2:0] TIME_TOP = '1;
endpackage

### hdl/sensor_hit_cluster_finder_core.sv
// Sensor hit cluster finder: entry stores, time cut, singles cut, cluster search.
// Depends on shcf_pkg.
//
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall  | opcode .. last_entry
// out     | output    | out_valid / out_stall| member_index, is_seed, last_member, status
// cfg     | input     | wr_en                | wr_data (singles_threshold)
//
// A plain load writes its entry into the stores. A last load runs the clean-up with
// N entries: a time cut, then per entry a neighbour search on one shared multiplier,
// then zeroing. A find runs a maximum search and a neighbour search, then gives
// one result per cycle while out_stall is low.
// in_stall is high whenever the sequencer is busy;
// out_stall holds the output register and the sequencer. Reset clears control only.
module sensor_hit_cluster_finder_core #(
	parameter int MAX_SENSORS     = shcf_pkg::MAX_SENSORS_DEF,
	parameter int NEIGHBOUR_COUNT = shcf_pkg::NEIGHBOUR_COUNT_DEF,
	parameter int CLUSTER_SIZE    = shcf_pkg::CLUSTER_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [shcf_pkg::THR_W-1:0]        wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              opcode,
	input  logic [shcf_pkg::IDX_W-1:0]        sensor_index,
	input  logic                              sensor_used,
	input  logic [shcf_pkg::CHG_W-1:0]        charge,
	input  logic signed [shcf_pkg::TIME_W-1:0] hit_time,
	input  logic signed [shcf_pkg::POS_W-1:0] pos_x,
	input  logic signed [shcf_pkg::POS_W-1:0] pos_y,
	input  logic signed [shcf_pkg::POS_W-1:0] pos_z,
	input  logic                              last_entry,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [shcf_pkg::IDX_W-1:0]        member_index,
	output logic                              is_seed,
	output logic                              last_member,
	output logic                              status
);
	import shcf_pkg::*;

	localparam int AW  = $clog2(MAX_SENSORS);
	localparam int CW  = $clog2(MAX_SENSORS + 1);
	localparam int LL0 = (NEIGHBOUR_COUNT > CLUSTER_SIZE - 1) ? NEIGHBOUR_COUNT
		: CLUSTER_SIZE - 1;
	localparam int LL  = (LL0 < 2) ? 2 : LL0;
	localparam int LW  = $clog2(LL);
	localparam int QW  = $clog2(LL + 1);
	localparam int PW  = 3 * POS_W;
	localparam int DW  = 2 * POS_W + 2;
	localparam int TW  = TIME_W - 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MED  = 4'd1;
	localparam logic [3:0] S_CUT  = 4'd2;
	localparam logic [3:0] S_POS  = 4'd3;
	localparam logic [3:0] S_NN   = 4'd4;
	localparam logic [3:0] S_CNT  = 4'd5;
	localparam logic [3:0] S_ZERO = 4'd6;
	localparam logic [3:0] S_MAX  = 4'd7;
	localparam logic [3:0] S_EMIT = 4'd8;

	localparam logic [QW-1:0] NB_K  = QW'(NEIGHBOUR_COUNT);
	localparam logic [QW-1:0] CL_K  = QW'(CLUSTER_SIZE - 1);
	localparam logic [CW-1:0] CL_N  = CW'(CLUSTER_SIZE);
	localparam logic [3:0]    IT_LAST = 4'(TW - 1);

	logic [CHG_W-1:0]  chg_mem [MAX_SENSORS];
	logic [TIME_W-1:0] tim_mem [MAX_SENSORS];
	logic [PW-1:0]     pos_mem [MAX_SENSORS];
	logic              kp_mem  [MAX_SENSORS];

	logic [AW-1:0]     rd_addr, wr_addr;
	logic              chg_we, tim_we, pos_we, kp_we, kp_wd;
	logic [CHG_W-1:0]  chg_wd, chg_rd_q;
	logic [TIME_W-1:0] tim_wd, tim_rd_q;
	logic [PW-1:0]     pos_wd, pos_rd_q;
	logic              kp_rd_q;

	logic [3:0]      state_q;
	logic [CW-1:0]   ec_q, s_q, i_q, n_q, c1_q, c2_q;
	logic            closed_q, mode_q, st_q, p_s1;
	logic [THR_W-1:0] thr_q;
	logic [2:0]      ph_q;
	logic [AW-1:0]   a_s1, seed_q;
	logic [TW-1:0]   lo1_q, hi1_q, lo2_q, hi2_q;
	logic [3:0]      it_q;
	logic [QW-1:0]   nn_n_q, cnt_q, e_q;
	logic [CHG_W-1:0] best_q;
	logic            out_valid_q;

	logic [PW-1:0]          pc_q;
	logic signed [17:0]     d_q [3];
	logic [DW-1:0]          acc_q;
	logic [DW-1:0]          dd_q [LL];
	logic [AW-1:0]          ix_q [LL];
	logic                   vl_q [LL];
	logic [IDX_W-1:0]       mi_q;
	logic                   seed_o_q, last_o_q, st_o_q;

	logic accept, out_free, pass_issue, pass_end;
	logic [31:0]   idx32;
	logic          idx_ok;
	logic [AW-1:0] ld_addr, c_addr;
	logic [CW-1:0] ec_base, ec_new;
	logic signed [TIME_W-1:0] t_rd;
	logic          t_pos;
	logic [TW-1:0] mid1, mid2;
	logic [CW-1:0] k1, k2;
	logic [TIME_W:0] tsum;
	logic signed [17:0] m_op;
	logic signed [35:0] sq_s;
	logic [DW-1:0] acc_nx;
	logic          gt [LL];
	logic [DW-1:0] ins_dd [LL];
	logic [AW-1:0] ins_ix [LL];
	logic          ins_vl [LL];
	logic [QW-1:0] m_cnt;
	logic [AW-1:0] em_addr;
	logic [31:0]   em32;

	function automatic logic pass_end_cnt();
		pass_end_cnt = !p_s1 && !((e_q < NB_K) && (e_q < nn_n_q));
	endfunction

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != S_IDLE);
	assign out_free   = !out_valid_q || !out_stall;
	assign pass_issue = (s_q < ec_q);
	assign pass_end   = !pass_issue && !p_s1;

	assign idx32   = 32'(sensor_index);
	assign idx_ok  = idx32 < 32'(MAX_SENSORS);
	assign ld_addr = idx32[AW-1:0];
	assign ec_base = closed_q ? '0 : ec_q;
	assign ec_new  = (CW'(ld_addr) + CW'(1) > ec_base) ? CW'(ld_addr) + CW'(1) : ec_base;
	assign c_addr  = mode_q ? seed_q : i_q[AW-1:0];

	assign t_rd  = $signed(tim_rd_q);
	assign t_pos = !t_rd[TIME_W-1] && (t_rd != '0);
	assign mid1  = TW'((TIME_W'(lo1_q) + TIME_W'(hi1_q)) >> 1);
	assign mid2  = TW'((TIME_W'(lo2_q) + TIME_W'(hi2_q)) >> 1);
	assign k1    = (n_q - CW'(1)) >> 1;
	assign k2    = n_q >> 1;
	assign tsum  = (TIME_W+1)'(lo1_q) + (TIME_W+1)'(lo2_q);

	assign m_op   = (ph_q == 3'd2) ? d_q[0] : (ph_q == 3'd3) ? d_q[1] : d_q[2];
	assign sq_s   = m_op * m_op;
	assign acc_nx = ((ph_q == 3'd2) ? '0 : acc_q) + DW'(sq_s);

	assign m_cnt   = (nn_n_q < CL_K) ? nn_n_q : CL_K;
	assign em_addr = (e_q == '0) ? seed_q : ix_q[LW'(e_q - QW'(1))];
	assign em32    = 32'(em_addr);

	always_comb begin
		for (int p = 0; p < LL; p++) begin
			gt[p] = !vl_q[p] || (dd_q[p] > acc_q);
		end
		for (int p = 0; p < LL; p++) begin
			ins_dd[p] = dd_q[p];
			ins_ix[p] = ix_q[p];
			ins_vl[p] = vl_q[p];
			if (gt[p]) begin
				if (p == 0 || !gt[(p == 0) ? 0 : p-1]) begin
					ins_dd[p] = acc_q;
					ins_ix[p] = s_q[AW-1:0];
					ins_vl[p] = 1'b1;
				end else begin
					ins_dd[p] = dd_q[(p == 0) ? 0 : p-1];
					ins_ix[p] = ix_q[(p == 0) ? 0 : p-1];
					ins_vl[p] = vl_q[(p == 0) ? 0 : p-1];
				end
			end
		end
	end

	always_comb begin
		rd_addr = s_q[AW-1:0];
		wr_addr = a_s1;
		chg_we  = 1'b0;
		tim_we  = 1'b0;
		pos_we  = 1'b0;
		kp_we   = 1'b0;
		chg_wd  = '0;
		tim_wd  = sensor_used ? hit_time : '0;
		pos_wd  = {pos_z, pos_y, pos_x};
		kp_wd   = {{THR_W{1'b0}}, cnt_q} > {{QW{1'b0}}, thr_q};
		case (state_q)
			S_IDLE: begin
				wr_addr = ld_addr;
				chg_wd  = sensor_used ? charge : '0;
				if (accept && !opcode && idx_ok) begin
					chg_we = 1'b1;
					tim_we = 1'b1;
					pos_we = 1'b1;
				end
			end
			S_CUT: begin
				chg_we = p_s1 && ($signed({t_rd[TIME_W-1], t_rd, 1'b0})
					> $signed({1'b0, tsum}));
			end
			S_POS: rd_addr = c_addr;
			S_NN: ;
			S_CNT: begin
				rd_addr = ix_q[LW'(e_q)];
				wr_addr = i_q[AW-1:0];
				kp_we   = pass_end_cnt();
			end
			S_ZERO: chg_we = p_s1 && !kp_rd_q;
			S_EMIT: begin
				wr_addr = em_addr;
				chg_we  = out_free && !st_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (chg_we) chg_mem[wr_addr] <= chg_wd;
		if (tim_we) tim_mem[wr_addr] <= tim_wd;
		if (pos_we) pos_mem[wr_addr] <= pos_wd;
		if (kp_we)  kp_mem[wr_addr]  <= kp_wd;
		chg_rd_q <= chg_mem[rd_addr];
		tim_rd_q <= tim_mem[rd_addr];
		pos_rd_q <= pos_mem[rd_addr];
		kp_rd_q  <= kp_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_POS && ph_q == 3'd1) pc_q <= pos_rd_q;
		if (state_q == S_NN && ph_q == 3'd1) begin
			for (int k = 0; k < 3; k++) begin
				d_q[k] <= 18'($signed(pos_rd_q[k*POS_W +: POS_W]))
					- 18'($signed(pc_q[k*POS_W +: POS_W]));
			end
		end
		if (state_q == S_NN && ph_q >= 3'd2 && ph_q <= 3'd4) acc_q <= acc_nx;
		if (state_q == S_NN && ph_q == 3'd5) begin
			for (int p = 0; p < LL; p++) begin
				dd_q[p] <= ins_dd[p];
				ix_q[p] <= ins_ix[p];
			end
		end
		if (state_q == S_EMIT && out_free) begin
			mi_q     <= st_q ? '0 : em32[IDX_W-1:0];
			seed_o_q <= !st_q && (e_q == '0);
			last_o_q <= st_q || (e_q == m_cnt);
			st_o_q   <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ec_q        <= '0;
			closed_q    <= 1'b0;
			thr_q       <= THR_RESET;
			s_q         <= '0;
			i_q         <= '0;
			n_q         <= '0;
			c1_q        <= '0;
			c2_q        <= '0;
			mode_q      <= 1'b0;
			st_q        <= 1'b0;
			p_s1        <= 1'b0;
			ph_q        <= '0;
			a_s1        <= '0;
			seed_q      <= '0;
			lo1_q       <= '0;
			hi1_q       <= '0;
			lo2_q       <= '0;
			hi2_q       <= '0;
			it_q        <= '0;
			nn_n_q      <= '0;
			cnt_q       <= '0;
			e_q         <= '0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
			for (int p = 0; p < LL; p++) vl_q[p] <= 1'b0;
		end else begin
			if (wr_en) thr_q <= wr_data;
			if (out_valid_q && !out_stall && state_q != S_EMIT) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && !opcode) begin
						if (closed_q) closed_q <= 1'b0;
						if (idx_ok) ec_q <= ec_new;
						else if (closed_q) ec_q <= '0;
						if (last_entry) begin
							state_q <= S_MED;
							s_q     <= '0;
							p_s1    <= 1'b0;
							n_q     <= '0;
							c1_q    <= '0;
							c2_q    <= '0;
							it_q    <= '0;
							lo1_q   <= TW'(1);
							lo2_q   <= TW'(1);
							hi1_q   <= TIME_TOP;
							hi2_q   <= TIME_TOP;
						end
					end else if (accept) begin
						e_q <= '0;
						if (ec_q < CL_N) begin
							st_q    <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							st_q    <= 1'b0;
							s_q     <= '0;
							p_s1    <= 1'b0;
							best_q  <= '0;
							seed_q  <= '0;
							state_q <= S_MAX;
						end
					end
				end
				S_MED: begin
					p_s1 <= pass_issue;
					a_s1 <= s_q[AW-1:0];
					if (pass_issue) s_q <= s_q + CW'(1);
					if (p_s1 && t_pos) begin
						n_q <= n_q + CW'(1);
						if ($signed({1'b0, mid1}) >= t_rd) c1_q <= c1_q + CW'(1);
						if ($signed({1'b0, mid2}) >= t_rd) c2_q <= c2_q + CW'(1);
					end
					if (pass_end) begin
						s_q  <= '0;
						n_q  <= '0;
						c1_q <= '0;
						c2_q <= '0;
						if (n_q == '0) begin
							mode_q  <= 1'b0;
							i_q     <= '0;
							ph_q    <= '0;
							state_q <= S_POS;
						end else begin
							if (c1_q > k1) hi1_q <= mid1;
							else lo1_q <= mid1 + TW'(1);
							if (c2_q > k2) hi2_q <= mid2;
							else lo2_q <= mid2 + TW'(1);
							it_q <= it_q + 4'd1;
							if (it_q == IT_LAST) state_q <= S_CUT;
						end
					end
				end
				S_CUT: begin
					p_s1 <= pass_issue;
					a_s1 <= s_q[AW-1:0];
					if (pass_issue) s_q <= s_q + CW'(1);
					if (pass_end) begin
						mode_q  <= 1'b0;
						i_q     <= '0;
						ph_q    <= '0;
						state_q <= S_POS;
					end
				end
				S_POS: begin
					if (ph_q == 3'd0) begin
						if (!mode_q && i_q == ec_q) begin
							s_q     <= '0;
							p_s1    <= 1'b0;
							state_q <= S_ZERO;
						end else begin
							ph_q <= 3'd1;
						end
					end else begin
						for (int p = 0; p < LL; p++) vl_q[p] <= 1'b0;
						nn_n_q  <= '0;
						s_q     <= '0;
						ph_q    <= '0;
						state_q <= S_NN;
					end
				end
				S_NN: begin
					case (ph_q)
						3'd0: begin
							if (s_q == ec_q) begin
								e_q   <= '0;
								cnt_q <= '0;
								p_s1  <= 1'b0;
								state_q <= mode_q ? S_EMIT : S_CNT;
							end else if (s_q[AW-1:0] == c_addr) begin
								s_q <= s_q + CW'(1);
							end else begin
								ph_q <= 3'd1;
							end
						end
						3'd5: begin
							for (int p = 0; p < LL; p++) vl_q[p] <= ins_vl[p];
							if (nn_n_q < QW'(LL)) nn_n_q <= nn_n_q + QW'(1);
							s_q  <= s_q + CW'(1);
							ph_q <= 3'd0;
						end
						default: ph_q <= ph_q + 3'd1;
					endcase
				end
				S_CNT: begin
					p_s1 <= (e_q < NB_K) && (e_q < nn_n_q);
					if ((e_q < NB_K) && (e_q < nn_n_q)) e_q <= e_q + QW'(1);
					if (p_s1 && chg_rd_q != '0) cnt_q <= cnt_q + QW'(1);
					if (pass_end_cnt()) begin
						i_q     <= i_q + CW'(1);
						ph_q    <= '0;
						state_q <= S_POS;
					end
				end
				S_ZERO: begin
					p_s1 <= pass_issue;
					a_s1 <= s_q[AW-1:0];
					if (pass_issue) s_q <= s_q + CW'(1);
					if (pass_end) begin
						closed_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_MAX: begin
					p_s1 <= pass_issue;
					a_s1 <= s_q[AW-1:0];
					if (pass_issue) s_q <= s_q + CW'(1);
					if (p_s1 && chg_rd_q > best_q) begin
						best_q <= chg_rd_q;
						seed_q <= a_s1;
					end
					if (pass_end) begin
						mode_q  <= 1'b1;
						ph_q    <= '0;
						state_q <= S_POS;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (st_q || e_q == m_cnt) state_q <= S_IDLE;
						else e_q <= e_q + QW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign member_index = mi_q;
	assign is_seed      = seed_o_q;
	assign last_member  = last_o_q;
	assign status       = st_o_q;
endmodule

### hdl/shcf_checker.sv
// Port checker for the sensor hit cluster finder, bound to the top level.
// Depends on shcf_pkg and sensor_hit_cluster_finder_core.
module shcf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [shcf_pkg::IDX_W-1:0] member_index,
	input logic                       is_seed,
	input logic                       last_member,
	input logic                       status
);
	import shcf_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(member_index) && $stable(is_seed))
		else $error("stalled result changed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last_member && !is_seed && member_index == '0)
		else $error("status result malformed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_member |-> in_stall)
		else $error("request taken during cluster run");
endmodule

bind sensor_hit_cluster_finder_core shcf_checker u_shcf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.member_index (member_index),
	.is_seed      (is_seed),
	.last_member  (last_member),
	.status       (status)
);
